// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and constants shared by the ring buffer deque files.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int CAP_W  = 7;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

  localparam logic [CAP_W-1:0]         CAP_RESET   = 7'd64;
  localparam logic [CAP_W-1:0]         CAP_REG_MAX = 7'd127;
  localparam logic signed [DATA_W-1:0] VALUE_EMPTY = -32'sd1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] data_value;
  } in_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

endpackage

// ===== rtl/rbd_store.sv =====
// ----------------------------------------------------------------------------
// rbd_store
// Slot memory: one write port and two registered read ports (front, rear).
// ----------------------------------------------------------------------------
module rbd_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rbd_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr_front,
  input  logic [AW-1:0]             rd_addr_rear,
  output logic [rbd_pkg::DATA_W-1:0] rd_front_r,
  output logic [rbd_pkg::DATA_W-1:0] rd_rear_r
);

  logic [rbd_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_front_r <= mem[rd_addr_front];
      rd_rear_r  <= mem[rd_addr_rear];
    end
  end

endmodule

// ===== rtl/ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue kept in a ring of slots with a configurable capacity.
// An accepted input beat updates the pointers, then the slot memory is read
// (registered) in READ and the result beat is loaded in SEND, which stalls
// while out_ready holds back a pending result; no new input is taken until IDLE.
// Reset (rst_n, synchronous, active low): pointers and count clear, capacity
// returns to 64; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rbd_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rbd_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rbd_pkg::CAP_W-1:0] cfg_data
);

  localparam int LIM = (DEPTH < 127) ? DEPTH : 127;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(LIM + 1);
  localparam int XW  = ((AW > rbd_pkg::CAP_W) ? AW : rbd_pkg::CAP_W) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx,
                                              input logic [XW-1:0] cap);
    logic [XW-1:0] ix;
    ix = XW'(idx);
    if (ix == '0 || ix >= cap) begin
      return AW'(cap - XW'(1));
    end
    return AW'(ix - XW'(1));
  endfunction

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx,
                                            input logic [XW-1:0] cap);
    logic [XW-1:0] ix;
    ix = XW'(idx) + XW'(1);
    if (ix >= cap) begin
      return '0;
    end
    return AW'(ix);
  endfunction

  logic [1:0]                state_r, state_nxt;
  logic [rbd_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [AW-1:0]             tail_r, tail_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      ok_r, ok_nxt;
  logic                      out_valid_r, out_valid_nxt;
  rbd_pkg::out_t             out_r, out_nxt;

  logic [XW-1:0]              cap_x;
  logic                       in_fire;
  logic                       full_now, empty_now;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr_rear;
  logic [rbd_pkg::DATA_W-1:0] rd_front, rd_rear;
  logic                       load_out;

  // Effective capacity: register value clamped to 1..LIM.
  always_comb begin
    if (cap_r == '0) begin
      cap_x = XW'(1);
    end else if (XW'(cap_r) > XW'(LIM)) begin
      cap_x = XW'(LIM);
    end else begin
      cap_x = XW'(cap_r);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign full_now  = XW'(count_r) >= cap_x;
  assign empty_now = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    cap_nxt   = cap_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    if (cfg_valid) begin
      cap_nxt   = cfg_data;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (in_fire) begin
      ok_nxt = 1'b0;
      unique case (in_data.kind)
        rbd_pkg::KIND_PUSH_FRONT: begin
          if (!full_now) begin
            head_nxt  = step_down(head_r, cap_x);
            wr_en     = 1'b1;
            wr_addr   = head_nxt;
            count_nxt = CW'(count_r + 1'b1);
            ok_nxt    = 1'b1;
          end
        end
        rbd_pkg::KIND_PUSH_BACK: begin
          if (!full_now) begin
            wr_en     = 1'b1;
            wr_addr   = tail_r;
            tail_nxt  = step_up(tail_r, cap_x);
            count_nxt = CW'(count_r + 1'b1);
            ok_nxt    = 1'b1;
          end
        end
        rbd_pkg::KIND_POP_FRONT: begin
          if (!empty_now) begin
            head_nxt  = step_up(head_r, cap_x);
            count_nxt = CW'(count_r - 1'b1);
            ok_nxt    = 1'b1;
          end
        end
        rbd_pkg::KIND_POP_BACK: begin
          if (!empty_now) begin
            tail_nxt  = step_down(tail_r, cap_x);
            count_nxt = CW'(count_r - 1'b1);
            ok_nxt    = 1'b1;
          end
        end
        rbd_pkg::KIND_QUERY: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // The read is issued in the cycle after the pointer update, so the write of a
  // push has already landed in the memory when its slot is read back.
  assign rd_en        = (state_r == ST_READ);
  assign rd_addr_rear = step_down(tail_r, cap_x);
  assign load_out     = (state_r == ST_SEND) && (!out_valid_r || out_ready);

  always_comb begin
    out_nxt.accepted    = ok_r;
    out_nxt.is_empty    = empty_now;
    out_nxt.is_full     = full_now;
    out_nxt.front_value = empty_now ? rbd_pkg::VALUE_EMPTY : $signed(rd_front);
    out_nxt.rear_value  = empty_now ? rbd_pkg::VALUE_EMPTY : $signed(rd_rear);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= rbd_pkg::CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  rbd_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (in_data.data_value),
    .rd_en        (rd_en),
    .rd_addr_front(head_r),
    .rd_addr_rear (rd_addr_rear),
    .rd_front_r   (rd_front),
    .rd_rear_r    (rd_rear)
  );

endmodule

// ===== rtl/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks for the ring buffer deque, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rbd_pkg::out_t out_data,
  input logic          cfg_valid,
  input logic          cfg_ready
);

  // A result beat that is stalled must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The block works on one item at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // An empty deque reports both end values as minus one.
  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.front_value == rbd_pkg::VALUE_EMPTY &&
      out_data.rear_value == rbd_pkg::VALUE_EMPTY)
    else $error("empty deque reported end values");

  // Capacity is at least one, so empty and full never coincide.
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("deque reported empty and full at once");

  // The user must write the capacity only while no item is in flight; the block does not enforce it.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_ready && !out_valid)
    else $error("capacity written while an item was in flight");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);
